### hw/rtl/sos_pkg.sv
`default_nettype none

package sos_pkg;

   // config register indexes
   localparam logic [1:0] CSR_EDGE_JUMP   = 2'd0;
   localparam logic [1:0] CSR_NEAR_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_WIDTH_LIMIT = 2'd2;

   localparam logic [15:0] EDGE_JUMP_RST   = 16'd320;
   localparam logic [15:0] NEAR_LIMIT_RST  = 16'd1600;
   localparam logic [15:0] WIDTH_LIMIT_RST = 16'd1600;

   localparam logic [4:0] MAX_OBJECTS = 5'd20;
   localparam logic [6:0] COUNT_MAX   = 7'd127;

   localparam int          TanEntries = 180;
   localparam logic [63:0] TanNum     = 64'd314;
   localparam logic [63:0] TanDen     = 64'd36000;
   localparam logic [63:0] Q30One     = 64'd1 << 30;

   typedef logic [31:0] tan_table_type [TanEntries];

   // shift-subtract quotient, only used while building the tangent table
   function automatic logic [63:0] ldiv_u64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = num;
      for (int b = 0; b < 64; b++) begin
         rem = {rem[63:0], quo[63]};
         quo = {quo[62:0], 1'b0};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tan(s*3.14/360) in unsigned q16, taylor series in q30
   function automatic logic [31:0] tan_entry(input logic [63:0] s);
      logic [63:0] x;
      logic [63:0] t;
      logic [63:0] sn;
      logic [63:0] cs;
      logic [63:0] q;
      logic [63:0] kk;
      x  = ldiv_u64((s * TanNum) << 30, TanDen);
      t  = Q30One;
      sn = '0;
      cs = Q30One;
      for (int k = 1; k <= 20; k++) begin
         kk = 64'(k);
         t  = ldiv_u64((t * x) >> 30, kk);
         if (kk[0]) begin
            if (kk[1:0] == 2'd1) sn = sn + t;
            else sn = sn - t;
         end else begin
            if (kk[1:0] == 2'd2) cs = cs - t;
            else cs = cs + t;
         end
      end
      if (cs == 64'd0 || cs >= (64'd1 << 40)) begin
         return 32'hFFFF_FFFF;
      end
      q = ldiv_u64(sn << 16, cs);
      if (q > 64'h0000_0000_FFFF_FFFF) begin
         return 32'hFFFF_FFFF;
      end
      return q[31:0];
   endfunction

   function automatic tan_table_type build_tan();
      tan_table_type tbl;
      for (int s = 0; s < TanEntries; s++) begin
         tbl[s] = tan_entry(64'(s));
      end
      return tbl;
   endfunction

   localparam tan_table_type TAN_Q16 = build_tan();

endpackage

`default_nettype wire

### hw/rtl/sweep_object_segmenter_top.sv
`default_nettype none

// sweep object segmenter
// one request per servo step: sweep_start, angle, ir range and sonar range
// (ranges in 1/16 cm). every request gives exactly one response with the
// object that this sample closed (if any), the object count and the aim angle
// of the narrowest object seen so far in the sweep.
// channels: req_* and rsp_* use valid/stall; an item moves when valid is high
// and stall is low. csr_* is a plain write port (edge_jump, near_limit,
// width_limit); the user must write it only while the block is idle, the block
// itself does not enforce it. steps: a sample that closes a recorded object
// passes edge evaluation, the shared bit-serial divider for the mean sonar
// range, a multiply with the tangent table and the finish step before its
// response is ready; every other sample goes from edge evaluation straight to
// the finish step. one request is in work at a time; req_stall stays high
// until the response is loaded.
// a stalled response sits in the output register; the next request may be
// taken meanwhile and waits in the finish step until the register frees up.
// reset (synchronous, active high) restores the register defaults and clears
// all sweep state; there is no clearing pass.
module sweep_object_segmenter_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_sweep_start,
   input  wire logic [7:0]  req_angle_deg,
   input  wire logic [15:0] req_ir_range,
   input  wire logic [15:0] req_sonar_range,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_object_done,
   output logic [7:0]       rsp_obj_start_angle,
   output logic [7:0]       rsp_obj_end_angle,
   output logic [15:0]      rsp_obj_distance,
   output logic [15:0]      rsp_obj_width,
   output logic [4:0]       rsp_object_count,
   output logic             rsp_aim_valid,
   output logic [7:0]       rsp_aim_angle,

   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import sos_pkg::*;

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic [4:0] DIV_LAST = 5'd22;

   // sequencer
   logic [2:0]  state_ff, state_in;

   // config
   logic [15:0] jump_ff, jump_in;
   logic [15:0] near_ff, near_in;
   logic [15:0] wlim_ff, wlim_in;

   // latched request
   logic [7:0]  angle_ff, angle_in;
   logic [15:0] ir_ff, ir_in;
   logic [15:0] sonar_ff, sonar_in;

   // sweep state
   logic [15:0] prev_ir_ff, prev_ir_in;
   logic        in_obj_ff, in_obj_in;
   logic [7:0]  start_ff, start_in;
   logic [22:0] sum_ff, sum_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [4:0]  nobj_ff, nobj_in;
   logic [15:0] best_w_ff, best_w_in;
   logic [7:0]  best_c_ff, best_c_in;
   logic        best_v_ff, best_v_in;

   // shared divider / multiplier datapath
   logic [22:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic [6:0]  div_ff, div_in;
   logic [4:0]  step_ff, step_in;
   logic [7:0]  span_ff, span_in;
   logic [23:0] tan_ff, tan_in;
   logic [39:0] prod_ff, prod_in;
   logic        done_ff, done_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        done_out_ff, done_out_in;
   logic [7:0]  ostart_ff, ostart_in;
   logic [7:0]  oend_ff, oend_in;
   logic [15:0] odist_ff, odist_in;
   logic [15:0] owidth_ff, owidth_in;
   logic [4:0]  ocount_ff, ocount_in;
   logic        oaimv_ff, oaimv_in;
   logic [7:0]  oaim_ff, oaim_in;

   // combinational helpers
   logic        req_take;
   logic        rsp_free;
   logic [15:0] drop_w;
   logic [15:0] rise_w;
   logic        lead_w;
   logic        close_w;
   logic [8:0]  trial_w;
   logic [7:0]  shifted_w;
   logic [15:0] mean_w;
   logic [15:0] width_w;
   logic [8:0]  center_w;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // edge tests against the previous ir range
   assign drop_w  = prev_ir_ff - ir_ff;
   assign rise_w  = ir_ff - prev_ir_ff;
   assign lead_w  = !in_obj_ff && (prev_ir_ff > ir_ff) && (drop_w > jump_ff)
                    && (ir_ff <= near_ff);
   assign close_w = in_obj_ff && (ir_ff > prev_ir_ff) && (rise_w > jump_ff)
                    && (prev_ir_ff <= near_ff);

   // one restoring divide step per cycle
   assign shifted_w = {rem_ff[6:0], quo_ff[22]};
   assign trial_w   = {1'b0, shifted_w} - {2'b00, div_ff};

   // a zero count means a zero mean
   assign mean_w = (div_ff == 7'd0) ? 16'd0 : quo_ff[15:0];

   // width = mean*2*tan >> 16, saturated
   always_comb begin
      if (!done_ff) begin
         width_w = 16'd0;
      end else if (span_ff >= 8'(TanEntries)) begin
         width_w = 16'hFFFF;
      end else if (prod_ff[39:31] != 9'd0) begin
         width_w = 16'hFFFF;
      end else begin
         width_w = prod_ff[30:15];
      end
   end

   assign center_w = {1'b0, start_ff} + {1'b0, angle_ff};

   always_comb begin
      state_in     = state_ff;
      jump_in      = jump_ff;
      near_in      = near_ff;
      wlim_in      = wlim_ff;
      angle_in     = angle_ff;
      ir_in        = ir_ff;
      sonar_in     = sonar_ff;
      prev_ir_in   = prev_ir_ff;
      in_obj_in    = in_obj_ff;
      start_in     = start_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      nobj_in      = nobj_ff;
      best_w_in    = best_w_ff;
      best_c_in    = best_c_ff;
      best_v_in    = best_v_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      span_in      = span_ff;
      tan_in       = tan_ff;
      prod_in      = prod_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      done_out_in  = done_out_ff;
      ostart_in    = ostart_ff;
      oend_in      = oend_ff;
      odist_in     = odist_ff;
      owidth_in    = owidth_ff;
      ocount_in    = ocount_ff;
      oaimv_in     = oaimv_ff;
      oaim_in      = oaim_ff;

      // response leaves
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes: the user is to write only while idle; the block does not enforce it
      if (csr_write) begin
         case (csr_index)
            CSR_EDGE_JUMP:   jump_in = csr_wdata;
            CSR_NEAR_LIMIT:  near_in = csr_wdata;
            CSR_WIDTH_LIMIT: wlim_in = csr_wdata;
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               angle_in = req_angle_deg;
               ir_in    = req_ir_range;
               sonar_in = req_sonar_range;
               state_in = ST_EVAL;
               // new sweep clears tracking before this sample is looked at
               if (req_sweep_start) begin
                  prev_ir_in = 16'd0;
                  in_obj_in  = 1'b0;
                  start_in   = 8'd0;
                  sum_in     = 23'd0;
                  cnt_in     = 7'd0;
                  nobj_in    = 5'd0;
                  best_w_in  = wlim_ff;
                  best_c_in  = 8'd0;
                  best_v_in  = 1'b0;
               end
            end
         end

         ST_EVAL: begin
            prev_ir_in = ir_ff;
            done_in    = 1'b0;
            state_in   = ST_FIN;
            if (lead_w) begin
               // leading sample is counted twice
               in_obj_in = 1'b1;
               start_in  = angle_ff;
               sum_in    = {6'd0, sonar_ff, 1'b0};
               cnt_in    = 7'd2;
            end else if (close_w) begin
               in_obj_in = 1'b0;
               sum_in    = 23'd0;
               cnt_in    = 7'd0;
               if (nobj_ff < MAX_OBJECTS) begin
                  quo_in   = sum_ff;
                  div_in   = cnt_ff;
                  rem_in   = 8'd0;
                  step_in  = 5'd0;
                  span_in  = (angle_ff >= start_ff) ? (angle_ff - start_ff)
                                                    : (start_ff - angle_ff);
                  done_in  = 1'b1;
                  state_in = ST_DIV;
               end
            end else if (in_obj_ff && (cnt_ff < COUNT_MAX)) begin
               sum_in = sum_ff + {7'd0, sonar_ff};
               cnt_in = cnt_ff + 7'd1;
            end
         end

         ST_DIV: begin
            tan_in = (span_ff < 8'(TanEntries)) ? TAN_Q16[span_ff][23:0] : 24'd0;
            if (!trial_w[8]) begin
               rem_in = trial_w[7:0];
               quo_in = {quo_ff[21:0], 1'b1};
            end else begin
               rem_in = shifted_w;
               quo_in = {quo_ff[21:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == DIV_LAST) begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            prod_in  = 40'(mean_w) * 40'(tan_ff);
            state_in = ST_FIN;
         end

         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               done_out_in  = done_ff;
               ostart_in    = done_ff ? start_ff : 8'd0;
               oend_in      = done_ff ? angle_ff : 8'd0;
               odist_in     = done_ff ? mean_w : 16'd0;
               owidth_in    = width_w;
               ocount_in    = nobj_ff;
               oaimv_in     = best_v_ff;
               oaim_in      = best_v_ff ? best_c_ff : 8'd0;
               if (done_ff) begin
                  nobj_in   = nobj_ff + 5'd1;
                  ocount_in = nobj_ff + 5'd1;
                  if (width_w < best_w_ff) begin
                     best_w_in = width_w;
                     best_c_in = center_w[8:1];
                     best_v_in = 1'b1;
                     oaimv_in  = 1'b1;
                     oaim_in   = center_w[8:1];
                  end
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         jump_ff      <= EDGE_JUMP_RST;
         near_ff      <= NEAR_LIMIT_RST;
         wlim_ff      <= WIDTH_LIMIT_RST;
         prev_ir_ff   <= 16'd0;
         in_obj_ff    <= 1'b0;
         start_ff     <= 8'd0;
         sum_ff       <= 23'd0;
         cnt_ff       <= 7'd0;
         nobj_ff      <= 5'd0;
         best_w_ff    <= WIDTH_LIMIT_RST;
         best_c_ff    <= 8'd0;
         best_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         jump_ff      <= jump_in;
         near_ff      <= near_in;
         wlim_ff      <= wlim_in;
         prev_ir_ff   <= prev_ir_in;
         in_obj_ff    <= in_obj_in;
         start_ff     <= start_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         nobj_ff      <= nobj_in;
         best_w_ff    <= best_w_in;
         best_c_ff    <= best_c_in;
         best_v_ff    <= best_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      ir_ff       <= ir_in;
      sonar_ff    <= sonar_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      span_ff     <= span_in;
      tan_ff      <= tan_in;
      prod_ff     <= prod_in;
      done_ff     <= done_in;
      done_out_ff <= done_out_in;
      ostart_ff   <= ostart_in;
      oend_ff     <= oend_in;
      odist_ff    <= odist_in;
      owidth_ff   <= owidth_in;
      ocount_ff   <= ocount_in;
      oaimv_ff    <= oaimv_in;
      oaim_ff     <= oaim_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_object_done     = done_out_ff;
   assign rsp_obj_start_angle = ostart_ff;
   assign rsp_obj_end_angle   = oend_ff;
   assign rsp_obj_distance    = odist_ff;
   assign rsp_obj_width       = owidth_ff;
   assign rsp_object_count    = ocount_ff;
   assign rsp_aim_valid       = oaimv_ff;
   assign rsp_aim_angle       = oaim_ff;

   // an accepted request keeps the input side closed in the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request taken while previous one still in work");

   // a reported object is always counted
   a_done_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_object_done) |-> (rsp_object_count != 5'd0))
      else $error("object reported with zero count");

   // no aim angle without a candidate
   a_aim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_aim_valid) |-> (rsp_aim_angle == 8'd0))
      else $error("aim angle without candidate");

   // object list never overruns
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      nobj_ff <= MAX_OBJECTS)
      else $error("object count above limit");

endmodule

`default_nettype wire

### bench/sweep_object_segmenter_top_tb.sv
module sweep_object_segmenter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // spans that the tangent table covers, wider spans saturate the width
   localparam int          TanSpans   = 180;
   // generous bound for ~850 requests
   localparam int unsigned CycleLimit = 500_000;
   // register index that the block decodes to nothing
   localparam logic [1:0]  CsrSpare   = 2'd3;

   // one response: closed object, count and aim
   typedef struct packed {
      logic        done;
      logic [7:0]  start_angle;
      logic [7:0]  end_angle;
      logic [15:0] distance;
      logic [15:0] obj_width;
      logic [4:0]  count;
      logic        aim_ok;
      logic [7:0]  aim_angle;
   } sweep_report_type;

   // object tracker: predicts each response and checks what comes back
   class segment_scoreboard;
      logic [31:0]      tan_q16 [TanSpans];
      logic [15:0]      edge_jump;
      logic [15:0]      near_limit;
      logic [15:0]      width_limit;
      logic [15:0]      prev_ir;
      logic             tracking;
      logic [7:0]       first_angle;
      logic [22:0]      sonar_acc;
      logic [6:0]       sample_cnt;
      logic [4:0]       n_objects;
      logic [15:0]      narrowest;
      logic [7:0]       aim_center;
      logic             aim_ok;
      sweep_report_type pending_reports [$];
      int unsigned      errors;
      int unsigned      responses_seen;

      function new();
         for (int s = 0; s < TanSpans; s++) tan_q16[s] = tangent_q16(s);
         edge_jump   = sos_pkg::EDGE_JUMP_RST;
         near_limit  = sos_pkg::NEAR_LIMIT_RST;
         width_limit = sos_pkg::WIDTH_LIMIT_RST;
         errors         = 0;
         responses_seen = 0;
         restart_sweep();
      endfunction

      // tan(s*3.14/360) in q16 from sine and cosine series in q30
      function logic [31:0] tangent_q16(int s);
         logic [63:0] x;
         logic [63:0] term;
         logic [63:0] sn;
         logic [63:0] cs;
         logic [63:0] q;
         x    = ((64'(s) * 64'd314) << 30) / 64'd36000;
         term = 64'd1 << 30;
         sn   = '0;
         cs   = 64'd1 << 30;
         for (int k = 1; k <= 20; k++) begin
            term = ((term * x) >> 30) / 64'(k);
            case (k % 4)
               1: sn = sn + term;
               2: cs = cs - term;
               3: sn = sn - term;
               default: cs = cs + term;
            endcase
         end
         if (cs == 64'd0 || cs >= (64'd1 << 40)) return 32'hFFFF_FFFF;
         q = (sn << 16) / cs;
         return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      endfunction

      function void restart_sweep();
         prev_ir     = '0;
         tracking    = 1'b0;
         first_angle = '0;
         sonar_acc   = '0;
         sample_cnt  = '0;
         n_objects   = '0;
         narrowest   = width_limit;
         aim_center  = '0;
         aim_ok      = 1'b0;
      endfunction

      function void set_register(logic [1:0] index, logic [15:0] value);
         case (index)
            sos_pkg::CSR_EDGE_JUMP:   edge_jump   = value;
            sos_pkg::CSR_NEAR_LIMIT:  near_limit  = value;
            sos_pkg::CSR_WIDTH_LIMIT: width_limit = value;
            default: ;
         endcase
      endfunction

      // accepted sample: advance the segmenter and queue its response
      function void note_sample(logic start, logic [7:0] ang, logic [15:0] ir,
                                logic [15:0] sonar);
         sweep_report_type r;
         logic [7:0]       span;
         logic [22:0]      mean;
         logic [63:0]      w;
         r = '0;
         if (start) restart_sweep();
         if (!tracking && prev_ir > ir && prev_ir - ir > edge_jump && ir <= near_limit) begin
            tracking    = 1'b1;
            first_angle = ang;
            sonar_acc   = 23'(sonar);
            sample_cnt  = 7'd1;
         end else if (tracking && ir > prev_ir && ir - prev_ir > edge_jump &&
                      prev_ir <= near_limit) begin
            if (n_objects < sos_pkg::MAX_OBJECTS) begin
               span = (ang >= first_angle) ? ang - first_angle : first_angle - ang;
               mean = (sample_cnt != 0) ? sonar_acc / 23'(sample_cnt) : '0;
               if (span >= TanSpans) begin
                  w = 64'hFFFF;
               end else begin
                  w = (64'(mean) * 64'd2 * 64'(tan_q16[span])) >> 16;
                  if (w > 64'hFFFF) w = 64'hFFFF;
               end
               r.done        = 1'b1;
               r.start_angle = first_angle;
               r.end_angle   = ang;
               r.distance    = mean[15:0];
               r.obj_width   = w[15:0];
               n_objects     = n_objects + 5'd1;
               if (w[15:0] < narrowest) begin
                  narrowest  = w[15:0];
                  aim_center = 8'((9'(first_angle) + 9'(ang)) >> 1);
                  aim_ok     = 1'b1;
               end
            end
            tracking   = 1'b0;
            sonar_acc  = '0;
            sample_cnt = '0;
         end
         // long objects freeze the sum once the count saturates
         if (tracking && sample_cnt < sos_pkg::COUNT_MAX) begin
            sonar_acc  = sonar_acc + 23'(sonar);
            sample_cnt = sample_cnt + 7'd1;
         end
         prev_ir     = ir;
         r.count     = n_objects;
         r.aim_ok    = aim_ok;
         r.aim_angle = aim_ok ? aim_center : 8'd0;
         pending_reports.push_back(r);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      task compare_field(string name, int unsigned seen, int unsigned want);
         if (seen != want)
            report_mismatch($sformatf("response %0d %s got %0d want %0d",
                                      responses_seen, name, seen, want));
      endtask

      task check_report(sweep_report_type seen);
         sweep_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch("response with no request waiting");
            return;
         end
         want = pending_reports.pop_front();
         compare_field("object_done", seen.done, want.done);
         compare_field("obj_start_angle", seen.start_angle, want.start_angle);
         compare_field("obj_end_angle", seen.end_angle, want.end_angle);
         compare_field("obj_distance", seen.distance, want.distance);
         compare_field("obj_width", seen.obj_width, want.obj_width);
         compare_field("object_count", seen.count, want.count);
         compare_field("aim_valid", seen.aim_ok, want.aim_ok);
         compare_field("aim_angle", seen.aim_angle, want.aim_angle);
         responses_seen++;
      endtask
   endclass

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_sweep_start = 1'b0;
   logic [7:0]  req_angle_deg   = '0;
   logic [15:0] req_ir_range    = '0;
   logic [15:0] req_sonar_range = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_object_done;
   logic [7:0]  rsp_obj_start_angle;
   logic [7:0]  rsp_obj_end_angle;
   logic [15:0] rsp_obj_distance;
   logic [15:0] rsp_obj_width;
   logic [4:0]  rsp_object_count;
   logic        rsp_aim_valid;
   logic [7:0]  rsp_aim_angle;
   logic        csr_write       = 1'b0;
   logic [1:0]  csr_index       = '0;
   logic [15:0] csr_wdata       = '0;

   segment_scoreboard tracker = new();

   int unsigned req_idle_pct = 0;   // chance of a gap before a request
   int unsigned rsp_idle_pct = 0;   // chance of a stall cycle on responses
   int unsigned samples_sent = 0;
   int unsigned cycle_count  = 0;

   sweep_object_segmenter_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sweep_start     (req_sweep_start),
      .req_angle_deg       (req_angle_deg),
      .req_ir_range        (req_ir_range),
      .req_sonar_range     (req_sonar_range),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_object_done     (rsp_object_done),
      .rsp_obj_start_angle (rsp_obj_start_angle),
      .rsp_obj_end_angle   (rsp_obj_end_angle),
      .rsp_obj_distance    (rsp_obj_distance),
      .rsp_obj_width       (rsp_obj_width),
      .rsp_object_count    (rsp_object_count),
      .rsp_aim_valid       (rsp_aim_valid),
      .rsp_aim_angle       (rsp_aim_angle),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, also the only way out if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("sweep_object_segmenter_top_tb: FAIL");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // every accepted request feeds the predictor at the edge it moves
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         tracker.note_sample(req_sweep_start, req_angle_deg, req_ir_range, req_sonar_range);
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_report(sweep_report_type'({rsp_object_done, rsp_obj_start_angle,
                                                  rsp_obj_end_angle, rsp_obj_distance,
                                                  rsp_obj_width, rsp_object_count,
                                                  rsp_aim_valid, rsp_aim_angle}));
   end

   // one request: optional gap, then hold it until the block takes it
   task automatic send_request(input logic start, input logic [7:0] ang,
                               input logic [15:0] ir, input logic [15:0] sonar);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_sweep_start <= start;
      req_angle_deg   <= ang;
      req_ir_range    <= ir;
      req_sonar_range <= sonar;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // sender holds off until every predicted response has come back
   task automatic wait_drained();
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_register(index, value);
   endtask

   // all three limits plus a write to the undecoded index, block idle
   task automatic write_settings(input logic [15:0] jump, input logic [15:0] near,
                                 input logic [15:0] widest);
      write_register(sos_pkg::CSR_EDGE_JUMP, jump);
      write_register(sos_pkg::CSR_NEAR_LIMIT, near);
      write_register(CsrSpare, 16'($urandom()));
      write_register(sos_pkg::CSR_WIDTH_LIMIT, widest);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // one sweep: far background with near dips that form objects,
   // some raw noise and a stray sweep start now and then
   task automatic run_sweep(input int unsigned n, input int unsigned open_pct,
                            input int unsigned close_pct, input bit long_obj);
      int unsigned far_r;
      int unsigned obj_ir;
      int unsigned ir;
      int unsigned sonar;
      int unsigned roll;
      bit          in_obj;
      logic        start;
      logic [7:0]  ang;
      ang    = 8'($urandom_range(0, 60));
      in_obj = 1'b0;
      obj_ir = 0;
      for (int unsigned i = 0; i < n; i++) begin
         far_r = int'(tracker.near_limit) + int'(tracker.edge_jump) + 1 +
                 $urandom_range(0, 3000);
         if (far_r > 65535) far_r = 65535;
         roll = $urandom_range(0, 99);
         if (!long_obj && roll < 8) begin
            ir = $urandom_range(0, 65535);
         end else if (!in_obj) begin
            if (i > 0 && (long_obj ? i == 1 : roll < open_pct)) begin
               obj_ir = $urandom_range(0, tracker.near_limit);
               ir     = obj_ir;
               in_obj = 1'b1;
            end else begin
               ir = far_r;
            end
         end else if (long_obj ? i >= n - 3 : roll < close_pct) begin
            ir     = far_r;
            in_obj = 1'b0;
         end else if (long_obj || roll < 80) begin
            ir = obj_ir;
         end else begin
            ir = $urandom_range(0, obj_ir);
         end
         roll = $urandom_range(0, 99);
         if (long_obj || roll < 5) sonar = 65535;
         else if (roll < 10) sonar = 0;
         else if (roll < 50) sonar = $urandom_range(0, 2000);
         else sonar = $urandom_range(0, 65535);
         if (i == 0) start = ($urandom_range(0, 9) != 0);
         else start = ($urandom_range(0, 49) == 0);
         send_request(start, ang, 16'(ir), 16'(sonar));
         if (!long_obj && $urandom_range(0, 19) == 0) ang = 8'($urandom_range(0, 255));
         else ang = ang + (long_obj ? 8'd1 : 8'($urandom_range(1, 3)));
      end
   endtask

   // random sweeps until the sample total reaches goal
   task automatic run_phase(input int unsigned goal, input bit with_long,
                            input bit pause_midway);
      int unsigned halfway;
      halfway = samples_sent + (goal - samples_sent) / 2;
      if (with_long) run_sweep(150, 0, 0, 1'b1);
      while (samples_sent < goal) begin
         // dense sweeps overflow the object list
         if ($urandom_range(0, 5) == 0) run_sweep($urandom_range(100, 130), 60, 60, 1'b0);
         else run_sweep($urandom_range(8, 60), 25, 30, 1'b0);
         if (pause_midway && samples_sent >= halfway) begin
            stop_sending();
            wait_drained();
            pause_midway = 1'b0;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender gaps rare, receiver stalls often
      req_idle_pct = 18;
      rsp_idle_pct = 58;

      // directed sweep at the reset limits
      send_request(1'b1, 8'd0, 16'hFFFF, 16'd0);
      send_request(1'b0, 8'd10, 16'd0, 16'hFFFF);      // full drop to zero opens
      send_request(1'b0, 8'd11, 16'd0, 16'hFFFF);
      send_request(1'b0, 8'd12, 16'hFFFF, 16'd1);      // full rise closes
      send_request(1'b0, 8'd20, 16'd1600, 16'd0);      // lands exactly on near limit
      send_request(1'b0, 8'd200, 16'd1921, 16'd7);     // span of 180: width saturates
      send_request(1'b0, 8'd30, 16'd1920, 16'd0);
      send_request(1'b0, 8'd31, 16'd1600, 16'd0);      // drop equal to jump: no edge
      send_request(1'b0, 8'd32, 16'd1279, 16'd100);    // drop one past jump opens
      send_request(1'b0, 8'd5, 16'd1599, 16'd200);
      send_request(1'b0, 8'd3, 16'd1920, 16'd300);     // closes below start: reversed span
      send_request(1'b0, 8'd255, 16'hFFFF, 16'd0);
      send_request(1'b0, 8'd250, 16'd1601, 16'd0);     // just above near limit: no edge
      send_request(1'b0, 8'd249, 16'd0, 16'd500);
      send_request(1'b0, 8'd248, 16'd0, 16'd500);
      send_request(1'b0, 8'd170, 16'hFFFF, 16'd500);
      send_request(1'b1, 8'd90, 16'hFFFF, 16'd9);      // new sweep drops the history
      send_request(1'b1, 8'd91, 16'd0, 16'd9);         // cleared previous range: no edge
      send_request(1'b0, 8'd92, 16'd1000, 16'd9);

      run_phase(300, 1'b1, 1'b1);
      stop_sending();
      wait_drained();

      // widest edge window, any object with an unsaturated width is an aim candidate
      write_settings(16'd0, 16'hFFFF, 16'hFFFF);
      req_idle_pct = 58;
      rsp_idle_pct = 18;
      run_phase(560, 1'b1, 1'b0);
      stop_sending();
      wait_drained();

      // no edge can ever fire, no object can ever be aimed at
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_settings(16'hFFFF, 16'd0, 16'd0);
      run_phase(600, 1'b0, 1'b0);
      stop_sending();
      wait_drained();

      write_settings(16'($urandom_range(100, 600)), 16'($urandom_range(800, 3000)),
                     16'($urandom_range(200, 4000)));
      run_phase(830, 1'b1, 1'b0);
      stop_sending();
      wait_drained();

      // leave room for a late closing object or anything stray
      repeat (40) @(posedge clock);
      if (tracker.pending_reports.size() != 0)
         tracker.report_mismatch("requests left without a response");
      if (tracker.errors == 0) begin
         $display("sweep_object_segmenter_top_tb: PASS");
      end else begin
         $display("sweep_object_segmenter_top_tb: FAIL");
      end
      $finish;
   end

endmodule
